FILE: hdl/trial_division_prime_test_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trial-division prime tester
// Clocked on clk and disabled while rst_n is low in the using module.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TDPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdpt assertion failed");

// next-cycle implication
`define TDPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdpt assertion failed");

`else

`define TDPT_ASSERT_IMP(label, ante, cons)
`define TDPT_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: hdl/tdpt_pkg.sv
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial-division prime tester.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_W      = 32;  // candidate field width
  localparam int IN_TDATA_W  = 32;  // candidate, byte padded
  localparam int OUT_TDATA_W = 8;   // is_prime, byte padded
  localparam int DIV_START   = 2;   // first trial divisor

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture candidate, divisor = 2
    logic init_div;  // clear remainder, restart bit counter
    logic div_step;  // one restoring remainder step
    logic next_div;  // divisor + 1, square follows
  } tdpt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below_two;  // number below 2
    logic past_root;  // divisor squared exceeds number
    logic div_last;   // last remainder step in progress
    logic rem_zero;   // remainder is zero
  } tdpt_sts_t;

endpackage

FILE: hdl/trial_division_prime_test.sv
// ---------------------------------------------------------------------------
// trial_division_prime_test
// Top level: reports whether an unsigned number is prime by trial division.
// ---------------------------------------------------------------------------
// Use:
//   Input stream in_*: one request per number (in_tdata). in_tready is high
//   only while no test is running, so one number is worked at a time.
//   Result stream out_*: one response per request, bit 0 of out_tdata is 1
//   for a prime. The response sits in an output register.
// Work per test: each divisor tried costs one bound check, NUM_WIDTH restoring
//   remainder steps (one bit a cycle) and one zero test. Numbers below 2,
//   2 and 3 are answered after the bound check alone, with no divisor step.
//   A new request is taken only once the previous test is done and the
//   controller is back in idle.
// Reset (rst_n low, synchronous): controller to idle, no response pending.
// Stall: a held response blocks the end of the following test only.
// Only the low NUM_WIDTH bits of the candidate are used.
// ---------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tdpt_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] candidate
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] is_prime, rest 0
);
  import tdpt_pkg::*;

  tdpt_cmd_t            cmd;
  tdpt_sts_t            sts;
  logic                 prime;
  logic [NUM_WIDTH-1:0] num_in;

  // truncate or zero-extend the candidate to the working width
  assign num_in = NUM_WIDTH'(in_tdata[CAND_W-1:0]);

  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_prime  (prime),
    .cmd        (cmd),
    .sts        (sts)
  );

  tdpt_dp #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk    (clk),
    .num_in (num_in),
    .cmd    (cmd),
    .sts    (sts)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, prime};

endmodule

FILE: hdl/tdpt_dp.sv
// ---------------------------------------------------------------------------
// tdpt_dp
// Datapath: held number, divisor with running square, bit-serial remainder.
// ---------------------------------------------------------------------------
module tdpt_dp #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [NUM_WIDTH-1:0]  num_in,
  input  tdpt_pkg::tdpt_cmd_t   cmd,
  output tdpt_pkg::tdpt_sts_t   sts
);
  import tdpt_pkg::*;

  localparam int DW = NUM_WIDTH / 2 + 1;       // divisor width
  localparam int SW = NUM_WIDTH + 2;           // square width
  localparam int CW = $clog2(NUM_WIDTH);       // bit counter width

  logic [NUM_WIDTH-1:0] num_r;
  logic [DW-1:0]        div_r,  div_nxt;
  logic [SW-1:0]        sq_r,   sq_nxt;
  logic [DW-1:0]        rem_r,  rem_nxt;
  logic [CW-1:0]        cnt_r,  cnt_nxt;
  logic [DW:0]          shifted;
  logic [DW:0]          diff;

  // one restoring step: bring down the next bit, subtract if it fits
  assign shifted = {rem_r, num_r[cnt_r]};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    div_nxt = div_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      div_nxt = DW'(DIV_START);
      sq_nxt  = SW'(DIV_START * DIV_START);
    end else if (cmd.next_div) begin
      div_nxt = div_r + 1'b1;
      sq_nxt  = sq_r + SW'({div_r, 1'b1});   // (d+1)^2 = d^2 + 2d + 1
    end
    if (cmd.init_div) begin
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_WIDTH - 1);
    end else if (cmd.div_step) begin
      rem_nxt = (shifted >= {1'b0, div_r}) ? diff[DW-1:0] : shifted[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= num_in;
    end
    div_r <= div_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.below_two = (num_r >> 1) == '0;
  assign sts.past_root = sq_r > SW'(num_r);
  assign sts.div_last  = cnt_r == '0;
  assign sts.rem_zero  = rem_r == '0;

endmodule

FILE: hdl/tdpt_ctrl.sv
// ---------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences the trials and holds the result register.
// ---------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_prime,
  output tdpt_pkg::tdpt_cmd_t  cmd,
  input  tdpt_pkg::tdpt_sts_t  sts
);
  import tdpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,   // bound test for the current divisor
    S_DIV,     // remainder steps
    S_TEST,    // zero remainder?
    S_DONE     // wait for free result slot
  } state_t;

  state_t state_r, state_nxt;
  logic   verdict_r, verdict_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_prime_r, out_prime_nxt;
  logic   slot_free;

  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt      = state_r;
    verdict_nxt    = verdict_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_prime_nxt  = out_prime_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.below_two) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (sts.past_root) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.init_div = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_prime_nxt  = verdict_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    verdict_r   <= verdict_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_prime  = out_prime_r;

  `TDPT_ASSERT_NXT(a_accept_to_check, in_tvalid && in_tready, state_r == S_CHECK)
  `TDPT_ASSERT_NXT(a_last_step_to_test, state_r == S_DIV && sts.div_last, state_r == S_TEST)
  `TDPT_ASSERT_NXT(a_done_delivers, state_r == S_DONE && slot_free,
                   state_r == S_IDLE && out_tvalid_r)
  `TDPT_ASSERT_IMP(a_new_result_from_done, $rose(out_tvalid_r), $past(state_r == S_DONE))

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: trial-division prime tester testbench
// Feeds candidates into the tester on the request stream and scores each
// prime/composite answer against an in-bench trial-division predictor.
// Covers directed corner numbers and then random numbers under four
// sender/receiver back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Random full-width candidates are capped to this many trial divisors.
  // Large primes would otherwise try every divisor up to their root.
  localparam int unsigned WIDE_TRIAL_CAP = 512;
  localparam int unsigned ITEMS_PER_PHASE = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts is_prime per accepted candidate, checks answers
  // in order.
  // --------------------------------------------------------------------------
  class prime_scoreboard;
    bit verdict_q[$];  // expected is_prime, oldest first
    int unsigned errors;

    // Trial division: divisors 2, 3, ... while d*d <= n. Stops on the
    // first zero remainder. Also reports how many divisors were tried.
    static function bit trial_divide(input bit [31:0] n, output int unsigned tries);
      longint unsigned num;
      longint unsigned d;
      tries = 0;
      num = n;
      if (num < 2) return 1'b0;
      for (d = 2; d <= num / d; d++) begin
        tries++;
        if (num % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(input bit [31:0] cand);
      int unsigned tries;
      verdict_q.push_back(trial_divide(cand, tries));
    endfunction

    function void check_answer(input logic [tdpt_pkg::OUT_TDATA_W-1:0] tdata);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual tdata=%h", $time, tdata);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (tdata[0] !== want) begin
        $display("%0t: is_prime mismatch, expected %0b, actual %b", $time, want, tdata[0]);
        errors++;
      end
      // pad bits above is_prime are documented as zero
      if (tdata[tdpt_pkg::OUT_TDATA_W-1:1] !== '0) begin
        $display("%0t: out_tdata pad mismatch, expected 0, actual %h",
                 $time, tdata[tdpt_pkg::OUT_TDATA_W-1:1]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tdpt_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [31:0] candidate
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tdpt_pkg::OUT_TDATA_W-1:0] out_tdata;      // [0] is_prime, [7:1] zero

  int unsigned idle_pct = 0;   // sender idle odds, percent per cycle
  int unsigned stall_pct = 0;  // receiver stall odds, percent per cycle

  prime_scoreboard sb = new();

  always #5 clk = ~clk;

  trial_division_prime_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Monitors: both handshakes sampled at the rising edge, before the
  // edge's nonblocking updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_candidate(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_answer(out_tdata);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  // Maybe idle a few cycles, then present one request and hold it until
  // accepted. Entered and left right after a rising edge.
  task automatic send_candidate(input bit [31:0] cand);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= cand;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sender holds off until every expected answer is back. Polled on the
  // falling edge so the monitor's pop at the rising edge has settled.
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Random candidate: tiny, 16-bit, or full width with the divisor count
  // kept under the cap (most wide numbers have a small factor anyway).
  function automatic bit [31:0] pick_candidate();
    bit [31:0] cand;
    int unsigned tries;
    case ($urandom_range(3))
      0: cand = $urandom_range(0, 31);
      1: cand = $urandom_range(0, 65535);
      default: begin
        do begin
          cand = $urandom;
          void'(prime_scoreboard::trial_divide(cand, tries));
        end while (tries > WIDE_TRIAL_CAP);
      end
    endcase
    return cand;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  bit [31:0] corner_nums[] = '{
    32'd0, 32'd1,                 // below two: never prime
    32'd2, 32'd3,                 // no divisor fits under the root
    32'd4, 32'd9, 32'd25, 32'd49, // squares hit the bound on equality
    32'd121, 32'd5, 32'd97,
    32'd65521,                    // largest 16-bit prime
    32'd65535, 32'd65536,
    32'd1048573,                  // prime near 2^20, ~1k divisors
    32'd1052651,                  // 1021 * 1031, two large factors
    32'd16752649,                 // 4093^2, composite only at the root
    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555
  };

  // {sender idle %, receiver stall %} per random phase
  int unsigned phase_idle[4]  = '{0, 79, 0, 26};
  int unsigned phase_stall[4] = '{0, 0, 79, 26};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, no idling on either side
    foreach (corner_nums[i]) send_candidate(corner_nums[i]);
    drain_answers();

    foreach (phase_idle[p]) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (ITEMS_PER_PHASE) send_candidate(pick_candidate());
      drain_answers();
    end

    stall_pct = 0;
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: bounds the slowest legal run (capped wide numbers plus the
  // directed square of 4093) and fails the regression if it is exceeded.
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/tdpt_pkg.sv
hdl/tdpt_dp.sv
hdl/tdpt_ctrl.sv
hdl/trial_division_prime_test.sv
dv/tb_top.sv
